// ===== design/hsv_color_adjust_macros.svh =====
// Assertion macros for the HSV color adjust block.
// Used by the top level; needs clk and rst in scope.
`ifndef HSV_COLOR_ADJUST_MACROS_SVH
`define HSV_COLOR_ADJUST_MACROS_SVH

// same-cycle implication
`define HCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// same-cycle implication, checked through reset
`define HCA_ASSERT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/hca_pkg.sv =====
// Shared constants, payload structs and a clamp helper for the HSV color adjust block.
// No dependencies.
package hca_pkg;

  localparam int HCA_FRAC      = 12;
  localparam int HCA_CW        = HCA_FRAC + 1;
  localparam int HCA_HUE_BITS  = 16;
  localparam int HCA_S_STEPS   = HCA_FRAC + 1;
  localparam int HCA_DIV_STEPS = HCA_HUE_BITS;
  localparam logic [HCA_CW-1:0] HCA_ONE = HCA_CW'(1) << HCA_FRAC;

  typedef struct packed {
    logic [12:0]        r;
    logic [12:0]        g;
    logic [12:0]        b;
    logic signed [12:0] shift;
    logic [13:0]        sgain;
    logic [13:0]        vgain;
  } hca_pix_t;

  typedef struct packed {
    logic [15:0]        hrem;
    logic [14:0]        hdiv;
    logic [15:0]        hq;
    logic [13:0]        srem;
    logic [12:0]        sdiv;
    logic [12:0]        sq;
    logic [12:0]        vmax;
    logic signed [12:0] shift;
    logic [13:0]        sgain;
    logic [13:0]        vgain;
  } hca_div_t;

  function automatic logic [12:0] hca_clamp(input logic signed [18:0] x);
    logic [12:0] y;
    if (x < 0) y = '0;
    else if (x > $signed(19'(HCA_ONE))) y = HCA_ONE;
    else y = x[12:0];
    return y;
  endfunction

endpackage

// ===== design/hca_to_hsv.sv =====
// Front end: input clamp, max/min, and hue and saturation numerator/denominator setup.
// Depends on hca_pkg.
module hca_to_hsv import hca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] red_in,
  input  logic [15:0] green_in,
  input  logic [15:0] blue_in,
  input  logic [12:0] hue_shift,
  input  logic [13:0] saturation_gain,
  input  logic [13:0] value_gain,
  output logic        out_valid,
  output hca_div_t    out_data
);

  hca_pix_t pix;
  logic     pix_valid;
  hca_div_t hsv_next;

  function automatic logic [12:0] clamp_in(input logic [15:0] x);
    logic [12:0] y;
    if ($signed(x) < 0) y = '0;
    else if ($signed(x) > $signed(16'(HCA_ONE))) y = HCA_ONE;
    else y = x[12:0];
    return y;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      pix_valid <= in_valid;
      out_valid <= pix_valid;
    end
    if (en) begin
      pix.r     <= clamp_in(red_in);
      pix.g     <= clamp_in(green_in);
      pix.b     <= clamp_in(blue_in);
      pix.shift <= $signed(hue_shift);
      pix.sgain <= saturation_gain;
      pix.vgain <= value_gain;
      out_data  <= hsv_next;
    end
  end

  logic [12:0]        cmax, cmin, cdelta;
  logic signed [16:0] n;
  logic [14:0]        d6;

  always_comb begin
    cmax = pix.r;
    cmin = pix.r;
    if (pix.g > cmax) cmax = pix.g;
    if (pix.b > cmax) cmax = pix.b;
    if (pix.g < cmin) cmin = pix.g;
    if (pix.b < cmin) cmin = pix.b;
    cdelta = cmax - cmin;
    d6 = 15'(cdelta) * 15'd6;
    if (pix.r == cmax) begin
      n = $signed(17'(pix.g)) - $signed(17'(pix.b));
      if (n < 0) n = n + $signed(17'(d6));
    end else if (pix.g == cmax) begin
      n = $signed(17'({cdelta, 1'b0})) + $signed(17'(pix.b)) - $signed(17'(pix.r));
    end else begin
      n = $signed(17'({cdelta, 2'b0})) + $signed(17'(pix.r)) - $signed(17'(pix.g));
    end
    hsv_next.hrem  = (cdelta == '0) ? '0 : 16'(n);
    hsv_next.hdiv  = (cdelta == '0) ? '1 : d6;
    hsv_next.hq    = '0;
    hsv_next.srem  = 14'(cdelta);
    hsv_next.sdiv  = (cmax == '0) ? '1 : cmax;
    hsv_next.sq    = '0;
    hsv_next.vmax  = cmax;
    hsv_next.shift = pix.shift;
    hsv_next.sgain = pix.sgain;
    hsv_next.vgain = pix.vgain;
  end

endmodule

// ===== design/hca_divider.sv =====
// Pipelined restoring divider: one quotient bit of hue per stage, and of saturation in the first HCA_S_STEPS stages.
// Depends on hca_pkg.
module hca_divider import hca_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  hca_div_t in_data,
  output logic     out_valid,
  output hca_div_t out_data
);

  hca_div_t stg      [HCA_DIV_STEPS];
  hca_div_t stg_next [HCA_DIV_STEPS];
  logic     vld      [HCA_DIV_STEPS];

  function automatic hca_div_t div_step(input hca_div_t x, input logic s_first,
                                        input logic s_on);
    hca_div_t    y;
    logic [15:0] ht;
    logic [13:0] st;
    y  = x;
    ht = {x.hrem[14:0], 1'b0};
    if (ht >= {1'b0, x.hdiv}) begin
      y.hrem = ht - {1'b0, x.hdiv};
      y.hq   = {x.hq[14:0], 1'b1};
    end else begin
      y.hrem = ht;
      y.hq   = {x.hq[14:0], 1'b0};
    end
    if (s_on) begin
      st = s_first ? x.srem : {x.srem[12:0], 1'b0};
      if (st >= {1'b0, x.sdiv}) begin
        y.srem = st - {1'b0, x.sdiv};
        y.sq   = {x.sq[11:0], 1'b1};
      end else begin
        y.srem = st;
        y.sq   = {x.sq[11:0], 1'b0};
      end
    end
    return y;
  endfunction

  always_comb begin
    for (int k = 0; k < HCA_DIV_STEPS; k++) begin
      stg_next[k] = div_step((k == 0) ? in_data : stg[(k == 0) ? 0 : k - 1],
                             k == 0, k < HCA_S_STEPS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HCA_DIV_STEPS; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < HCA_DIV_STEPS; k++) vld[k] <= vld[k-1];
    end
    if (en) begin
      for (int k = 0; k < HCA_DIV_STEPS; k++) stg[k] <= stg_next[k];
    end
  end

  assign out_valid = vld[HCA_DIV_STEPS-1];
  assign out_data  = stg[HCA_DIV_STEPS-1];

endmodule

// ===== design/hca_to_rgb.sv =====
// Back end: hue offset, gains, six-sector conversion and output clamp.
// Depends on hca_pkg.
module hca_to_rgb import hca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  hca_div_t    in_data,
  output logic        out_valid,
  output logic [12:0] red_out,
  output logic [12:0] green_out,
  output logic [12:0] blue_out
);

  logic [2:0] vld;

  logic [15:0] c1_hue;
  logic [13:0] c1_s, c1_v;

  logic [2:0]  c2_sec;
  logic [13:0] c2_s, c2_v, c2_sf, c2_s1f;

  logic [2:0]         c3_sec;
  logic               c3_szero;
  logic [13:0]        c3_v;
  logic signed [18:0] c3_p, c3_q, c3_t;

  logic [15:0] hue_sum;
  logic [18:0] h6;
  logic [31:0] sf_prod, s1f_prod;
  logic signed [15:0] a_p, a_q, a_t;
  logic signed [31:0] v_ext;
  logic signed [18:0] ro, go, bo, vv;

  always_comb begin
    hue_sum  = in_data.hq + (16'(in_data.shift) << (HCA_HUE_BITS - HCA_FRAC))
             + (16'(1) << (HCA_HUE_BITS - 1));
    h6       = 19'(c1_hue) * 19'd6;
    sf_prod  = 32'(c1_s) * 32'(h6[15:0]);
    s1f_prod = 32'(c1_s) * (32'(1) << HCA_HUE_BITS) - sf_prod;
    a_p = $signed(16'(HCA_ONE)) - $signed(16'(c2_s));
    a_q = $signed(16'(HCA_ONE)) - $signed(16'(c2_sf));
    a_t = $signed(16'(HCA_ONE)) - $signed(16'(c2_s1f));
    v_ext = $signed({18'd0, c2_v});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[1:0], in_valid};
      out_valid <= vld[2];
    end
    if (en) begin
      c1_hue <= hue_sum;
      c1_s   <= 14'((27'(in_data.sq) * 27'(in_data.sgain)) >> HCA_FRAC);
      c1_v   <= 14'((27'(in_data.vmax) * 27'(in_data.vgain)) >> HCA_FRAC);

      c2_sec <= h6[18:16];
      c2_s   <= c1_s;
      c2_v   <= c1_v;
      c2_sf  <= 14'(sf_prod >> HCA_HUE_BITS);
      c2_s1f <= 14'(s1f_prod >> HCA_HUE_BITS);

      c3_sec   <= c2_sec;
      c3_szero <= (c2_s == '0);
      c3_v     <= c2_v;
      c3_p     <= 19'((v_ext * 32'(a_p)) >>> HCA_FRAC);
      c3_q     <= 19'((v_ext * 32'(a_q)) >>> HCA_FRAC);
      c3_t     <= 19'((v_ext * 32'(a_t)) >>> HCA_FRAC);

      red_out   <= hca_clamp(ro);
      green_out <= hca_clamp(go);
      blue_out  <= hca_clamp(bo);
    end
  end

  always_comb begin
    vv = $signed(19'(c3_v));
    ro = vv; go = vv; bo = vv;
    if (!c3_szero) begin
      case (c3_sec)
        3'd0:    begin ro = vv;   go = c3_t; bo = c3_p; end
        3'd1:    begin ro = c3_q; go = vv;   bo = c3_p; end
        3'd2:    begin ro = c3_p; go = vv;   bo = c3_t; end
        3'd3:    begin ro = c3_p; go = c3_q; bo = vv;   end
        3'd4:    begin ro = c3_t; go = c3_p; bo = vv;   end
        default: begin ro = vv;   go = c3_p; bo = c3_q; end
      endcase
    end
  end

endmodule

// ===== design/hsv_color_adjust.sv =====
// HSV hue/saturation/value adjust, one pixel per cycle while the output is not stalled.
// Throughput 1 pixel/cycle while the output register is empty or taken.
// Every stage advances together whenever the output register is empty or taken.
// Reset clears all valid bits; payload registers are not reset.
// Depends on hca_pkg, hca_to_hsv, hca_divider, hca_to_rgb, hsv_color_adjust_macros.svh.
`include "hsv_color_adjust_macros.svh"
module hsv_color_adjust import hca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // red_in[15:0], green_in[31:16], blue_in[47:32],
                                 // hue_shift[60:48], saturation_gain[74:61],
                                 // value_gain[88:75], zero[95:89]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // red_out[12:0], green_out[25:13], blue_out[38:26], zero[39]
);

  logic     en;
  logic     hsv_valid, div_valid;
  hca_div_t hsv_data, div_data;
  logic [12:0] red_out, green_out, blue_out;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  hca_to_hsv u_to_hsv (
    .clk, .rst, .en,
    .in_valid        (s_tvalid),
    .red_in          (s_tdata[15:0]),
    .green_in        (s_tdata[31:16]),
    .blue_in         (s_tdata[47:32]),
    .hue_shift       (s_tdata[60:48]),
    .saturation_gain (s_tdata[74:61]),
    .value_gain      (s_tdata[88:75]),
    .out_valid       (hsv_valid),
    .out_data        (hsv_data)
  );

  hca_divider u_divider (
    .clk, .rst, .en,
    .in_valid  (hsv_valid),
    .in_data   (hsv_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  hca_to_rgb u_to_rgb (
    .clk, .rst, .en,
    .in_valid  (div_valid),
    .in_data   (div_data),
    .out_valid (m_tvalid),
    .red_out,
    .green_out,
    .blue_out
  );

  assign m_tdata = {1'b0, blue_out, green_out, red_out};

  `HCA_ASSERT_NOW(a_out_range, m_tvalid, (red_out <= HCA_ONE) && (green_out <= HCA_ONE) && (blue_out <= HCA_ONE))
  `HCA_ASSERT_NOW(a_sat_range, div_valid, div_data.sq <= HCA_ONE)
  `HCA_ASSERT_ANY(a_reset_empty, $fell(rst), !m_tvalid && !div_valid && !hsv_valid)

endmodule
